### rtl/skct_pkg.sv
// shared types and constants of the sorted keyed count table
package skct_pkg;

	localparam int OP_W  = 3;
	localparam int KEY_W = 24;
	localparam int CNT_W = 32;
	localparam int ST_W  = 2;
	localparam int ENT_W = 5;
	localparam int ROW_W = KEY_W + CNT_W;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
	localparam logic [OP_W-1:0] OP_MERGE  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_EXISTS    = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_IDX_DN,
		ADDR_IDX_UP,
		ADDR_POS
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_MOVE,
		WD_NEW,
		WD_SUM
	} wdata_sel_t;

	typedef enum logic [1:0] {
		CNT_ZERO,
		CNT_RD,
		CNT_AMT,
		CNT_SUM
	} cnt_sel_t;

	typedef struct packed {
		logic             load_cmd;
		logic             idx_clr;
		logic             idx_fill;
		logic             idx_inc;
		logic             idx_dec;
		logic             pos_load;
		logic             pos_hit;
		logic             rd_en;
		addr_sel_t        rd_addr;
		logic             wr_en;
		addr_sel_t        wr_addr;
		wdata_sel_t       wr_data;
		logic             fill_inc;
		logic             fill_dec;
		logic             res_load;
		logic [ST_W-1:0]  res_status;
		cnt_sel_t         res_cnt;
		logic             out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic            idx_at_fill;
		logic            idx_at_pos;
		logic            up_at_end;
		logic            key_lt;
		logic            key_eq;
		logic            hit;
		logic            full;
		logic [OP_W-1:0] op;
		logic            out_free;
	} dp_sts_t;

endpackage

### rtl/skct_ctrl.sv
// command sequencer of the sorted keyed count table
module skct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  skct_pkg::dp_sts_t  sts,
	output skct_pkg::ctl_cmd_t cmd
);

	skct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skct_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			skct_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_cmd = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_d      = skct_pkg::S_SCAN_RD;
				end
			end
			skct_pkg::S_SCAN_RD: begin
				if (sts.idx_at_fill) begin
					// ran off the end of the valid entries
					cmd.pos_load = 1'b1;
					cmd.pos_hit  = 1'b0;
					state_d      = skct_pkg::S_DECIDE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = skct_pkg::ADDR_IDX;
					state_d     = skct_pkg::S_SCAN_CMP;
				end
			end
			skct_pkg::S_SCAN_CMP: begin
				if (sts.key_lt) begin
					cmd.idx_inc = 1'b1;
					state_d     = skct_pkg::S_SCAN_RD;
				end else begin
					cmd.pos_load = 1'b1;
					cmd.pos_hit  = sts.key_eq;
					state_d      = skct_pkg::S_DECIDE;
				end
			end
			skct_pkg::S_DECIDE: begin
				state_d        = skct_pkg::S_DONE;
				cmd.res_load   = 1'b1;
				cmd.res_status = skct_pkg::ST_NOT_FOUND;
				cmd.res_cnt    = skct_pkg::CNT_ZERO;
				case (sts.op)
					skct_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.res_status = skct_pkg::ST_FULL;
						end else if (sts.hit) begin
							cmd.res_status = skct_pkg::ST_EXISTS;
						end else begin
							cmd.res_load = 1'b0;
							cmd.idx_fill = 1'b1;
							state_d      = skct_pkg::S_UP_RD;
						end
					end
					skct_pkg::OP_SEARCH: begin
						if (sts.hit) begin
							cmd.res_status = skct_pkg::ST_OK;
							cmd.res_cnt    = skct_pkg::CNT_RD;
						end
					end
					skct_pkg::OP_UPDATE: begin
						if (sts.hit) begin
							cmd.wr_en      = 1'b1;
							cmd.wr_addr    = skct_pkg::ADDR_POS;
							cmd.wr_data    = skct_pkg::WD_SUM;
							cmd.res_status = skct_pkg::ST_OK;
							cmd.res_cnt    = skct_pkg::CNT_SUM;
						end
					end
					skct_pkg::OP_ERASE: begin
						if (sts.hit) begin
							cmd.res_status = skct_pkg::ST_OK;
							cmd.res_cnt    = skct_pkg::CNT_RD;
							state_d        = skct_pkg::S_DN_RD;
						end
					end
					skct_pkg::OP_MERGE: begin
						if (sts.hit) begin
							cmd.wr_en      = 1'b1;
							cmd.wr_addr    = skct_pkg::ADDR_POS;
							cmd.wr_data    = skct_pkg::WD_SUM;
							cmd.res_status = skct_pkg::ST_OK;
							cmd.res_cnt    = skct_pkg::CNT_SUM;
						end else if (sts.full) begin
							cmd.res_status = skct_pkg::ST_FULL;
						end else begin
							cmd.res_load = 1'b0;
							cmd.idx_fill = 1'b1;
							state_d      = skct_pkg::S_UP_RD;
						end
					end
					default: begin
					end
				endcase
			end
			skct_pkg::S_UP_RD: begin
				if (sts.idx_at_pos) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_addr    = skct_pkg::ADDR_POS;
					cmd.wr_data    = skct_pkg::WD_NEW;
					cmd.fill_inc   = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_status = skct_pkg::ST_OK;
					cmd.res_cnt    = skct_pkg::CNT_AMT;
					state_d        = skct_pkg::S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = skct_pkg::ADDR_IDX_DN;
					state_d     = skct_pkg::S_UP_WR;
				end
			end
			skct_pkg::S_UP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = skct_pkg::ADDR_IDX;
				cmd.wr_data = skct_pkg::WD_MOVE;
				cmd.idx_dec = 1'b1;
				state_d     = skct_pkg::S_UP_RD;
			end
			skct_pkg::S_DN_RD: begin
				if (sts.up_at_end) begin
					cmd.fill_dec = 1'b1;
					state_d      = skct_pkg::S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = skct_pkg::ADDR_IDX_UP;
					state_d     = skct_pkg::S_DN_WR;
				end
			end
			skct_pkg::S_DN_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = skct_pkg::ADDR_IDX;
				cmd.wr_data = skct_pkg::WD_MOVE;
				cmd.idx_inc = 1'b1;
				state_d     = skct_pkg::S_DN_RD;
			end
			skct_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = skct_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skct_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/skct_dp.sv
// entry memory, walk counters, saturating adder and output register
module skct_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [skct_pkg::OP_W-1:0]     in_op,
	input  logic [skct_pkg::KEY_W-1:0]    in_key,
	input  logic signed [skct_pkg::CNT_W-1:0] in_amt,
	input  skct_pkg::ctl_cmd_t            cmd,
	output skct_pkg::dp_sts_t             sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [skct_pkg::ST_W-1:0]     out_status,
	output logic signed [skct_pkg::CNT_W-1:0] out_cnt,
	output logic [skct_pkg::ENT_W-1:0]    out_entries
);

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = skct_pkg::CNT_W;
	localparam int KW = skct_pkg::KEY_W;
	localparam int RW = skct_pkg::ROW_W;

	logic [RW-1:0] mem_q [CAPACITY];
	logic [RW-1:0] rd_q;

	logic [skct_pkg::OP_W-1:0] op_q;
	logic [KW-1:0]             key_q;
	logic signed [CW-1:0]      amt_q;
	logic [IW-1:0]             idx_q, pos_q, fill_q;
	logic                      hit_q;
	logic [skct_pkg::ST_W-1:0] res_status_q;
	logic signed [CW-1:0]      res_cnt_q;
	logic                      out_valid_q;
	logic [skct_pkg::ST_W-1:0] out_status_q;
	logic signed [CW-1:0]      out_cnt_q;
	logic [skct_pkg::ENT_W-1:0] out_entries_q;

	logic [IW-1:0]        idx_dn, idx_up, rd_sel, wr_sel;
	logic [KW-1:0]        rd_key;
	logic signed [CW-1:0] rd_cnt;
	logic signed [CW:0]   sum_wide;
	logic signed [CW-1:0] sum_sat;
	logic [RW-1:0]        wdata;
	logic signed [CW-1:0] cnt_pick;

	assign idx_dn = idx_q - IW'(1);
	assign idx_up = idx_q + IW'(1);
	assign rd_key = rd_q[RW-1:CW];
	assign rd_cnt = rd_q[CW-1:0];

	// 33-bit sum, clamped to the signed 32-bit range
	assign sum_wide = {rd_cnt[CW-1], rd_cnt} + {amt_q[CW-1], amt_q};
	always_comb begin
		if (sum_wide[CW] != sum_wide[CW-1]) begin
			sum_sat = sum_wide[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[CW-1:0];
		end
	end

	always_comb begin
		case (cmd.rd_addr)
			skct_pkg::ADDR_IDX_DN: rd_sel = idx_dn;
			skct_pkg::ADDR_IDX_UP: rd_sel = idx_up;
			skct_pkg::ADDR_POS:    rd_sel = pos_q;
			default:               rd_sel = idx_q;
		endcase
		case (cmd.wr_addr)
			skct_pkg::ADDR_IDX_DN: wr_sel = idx_dn;
			skct_pkg::ADDR_IDX_UP: wr_sel = idx_up;
			skct_pkg::ADDR_POS:    wr_sel = pos_q;
			default:               wr_sel = idx_q;
		endcase
		case (cmd.wr_data)
			skct_pkg::WD_NEW: wdata = {key_q, amt_q};
			skct_pkg::WD_SUM: wdata = {rd_key, sum_sat};
			default:          wdata = rd_q;
		endcase
		case (cmd.res_cnt)
			skct_pkg::CNT_RD:  cnt_pick = rd_cnt;
			skct_pkg::CNT_AMT: cnt_pick = amt_q;
			skct_pkg::CNT_SUM: cnt_pick = sum_sat;
			default:           cnt_pick = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_sel[AW-1:0]] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_sel[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cmd) begin
			op_q  <= in_op;
			key_q <= in_key;
			amt_q <= in_amt;
		end
		if (cmd.pos_load) begin
			pos_q <= idx_q;
			hit_q <= cmd.pos_hit;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_cnt_q    <= cnt_pick;
		end
		if (cmd.out_load) begin
			out_status_q  <= res_status_q;
			out_cnt_q     <= res_cnt_q;
			out_entries_q <= skct_pkg::ENT_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_fill) begin
				idx_q <= fill_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_up;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_dn;
			end
			if (cmd.fill_inc) begin
				fill_q <= fill_q + IW'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - IW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.idx_at_fill = (idx_q == fill_q);
		sts.idx_at_pos  = (idx_q == pos_q);
		sts.up_at_end   = (idx_up >= fill_q);
		sts.key_lt      = (rd_key < key_q);
		sts.key_eq      = (rd_key == key_q);
		sts.hit         = hit_q;
		sts.full        = (fill_q == IW'(CAPACITY));
		sts.op          = op_q;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_cnt     = out_cnt_q;
	assign out_entries = out_entries_q;

endmodule

### rtl/sorted_keyed_count_table_unit.sv
// top level of the sorted keyed count table: stream ports, sequencer and datapath
// operation: search, update and misses walk the slots before the key;
//   insert then shifts the tail up and erase shifts it down over the entry memory
// one command at a time: a new command is taken only after its result is loaded
//   into the output register, which waits while a full output register is stalled
// reset: arst_n clears sequencer, fill level and output valid; entry memory is not cleared
module sorted_keyed_count_table_unit #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // part_key [23:0], amount [55:24]
	input  logic [2:0]  s_tuser,   // opcode [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // count_out [31:0], entries [36:32], zero [39:37]
	output logic [1:0]  m_tuser    // status [1:0]
);

	skct_pkg::ctl_cmd_t cmd;
	skct_pkg::dp_sts_t  sts;

	logic [skct_pkg::ST_W-1:0]        out_status;
	logic signed [skct_pkg::CNT_W-1:0] out_cnt;
	logic [skct_pkg::ENT_W-1:0]       out_entries;

	// sequencer: walk, decide, shift, then hand the result to the output register
	skct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry memory and the registers around it
	skct_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_op       (s_tuser),
		.in_key      (s_tdata[23:0]),
		.in_amt      (s_tdata[55:24]),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_status  (out_status),
		.out_cnt     (out_cnt),
		.out_entries (out_entries)
	);

	// result transfer packing
	assign m_tdata = {3'b000, out_entries, out_cnt};
	assign m_tuser = out_status;

endmodule

### rtl/skct_checker.sv
// port-level checks of the sorted keyed count table, bound to the top level
module skct_checker #(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// one command in flight: no transfer right after an accepted one
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while busy");

	// any failure reports a zero count
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != skct_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
		else $error("nonzero count on failure");

	// table full only with the table at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == skct_pkg::ST_FULL) |-> (m_tdata[36:32] == 5'(CAPACITY)))
		else $error("full reported below capacity");

	// entry count never exceeds the capacity
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 31) || (32'(m_tdata[36:32]) <= CAPACITY))
		else $error("entry count above capacity");

endmodule

bind sorted_keyed_count_table_unit skct_checker #(
	.CAPACITY (CAPACITY)
) u_skct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### sim/sorted_keyed_count_table_unit_tb.sv
// testbench of the sorted keyed count table: queued command stream, in-bench table model, reply check
`timescale 1ns / 100ps

module sorted_keyed_count_table_unit_tb;

	localparam int CAPACITY = 16;
	localparam int KEY_POOL = 20;          // more keys than slots so the table runs full
	localparam int RANDOM_CMDS = 1230;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;     // longer than the worst command

	// opcodes that the block treats as no operation
	localparam logic [skct_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [skct_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

	localparam logic signed [skct_pkg::CNT_W-1:0] CNT_MAX = 32'sh7fffffff;
	localparam logic signed [skct_pkg::CNT_W-1:0] CNT_MIN = 32'sh80000000;
	localparam logic [skct_pkg::KEY_W-1:0] KEY_TOP = 24'hffffff;
	localparam logic [skct_pkg::KEY_W-1:0] KEY_MID = 24'h800000;

	typedef struct {
		logic [skct_pkg::OP_W-1:0]         op;
		logic [skct_pkg::KEY_W-1:0]        key;
		logic signed [skct_pkg::CNT_W-1:0] amount;
	} command_t;

	typedef struct {
		logic [skct_pkg::ST_W-1:0]         status;
		logic signed [skct_pkg::CNT_W-1:0] count;
		logic [skct_pkg::ENT_W-1:0]        entries;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;     // part_key [23:0], amount [55:24]
	logic [2:0]  s_tuser = '0;     // opcode [2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // count_out [31:0], entries [36:32], zero [39:37]
	logic [1:0]  m_tuser;          // status [1:0]

	command_t cmd_queue[$];        // commands not yet offered to the block
	reply_t   due_replies[$];      // predicted replies in transfer order

	// model of the table contents
	logic [skct_pkg::KEY_W-1:0]        tab_key[CAPACITY];
	logic signed [skct_pkg::CNT_W-1:0] tab_cnt[CAPACITY];
	int                                tab_fill = 0;

	int   errors = 0;
	int   cyc = 0;
	int   got_replies = 0;
	int   hold_left = 0;
	int   hold_mark = -1;
	logic in_xfer = 1'b0;

	sorted_keyed_count_table_unit #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// signed add clamped to the 32-bit limits
	function automatic logic signed [skct_pkg::CNT_W-1:0] sat_sum(
			logic signed [skct_pkg::CNT_W-1:0] a, logic signed [skct_pkg::CNT_W-1:0] b);
		logic [skct_pkg::CNT_W:0] s;
		s = {a[skct_pkg::CNT_W-1], a} + {b[skct_pkg::CNT_W-1], b};
		if (s[skct_pkg::CNT_W] != s[skct_pkg::CNT_W-1])
			return s[skct_pkg::CNT_W] ? CNT_MIN : CNT_MAX;
		return s[skct_pkg::CNT_W-1:0];
	endfunction

	// open a slot at pos by moving the tail up one place
	function automatic void insert_entry(int pos, logic [skct_pkg::KEY_W-1:0] key,
			logic signed [skct_pkg::CNT_W-1:0] amount);
		for (int i = tab_fill; i > pos; i--) begin
			tab_key[i] = tab_key[i-1];
			tab_cnt[i] = tab_cnt[i-1];
		end
		tab_key[pos] = key;
		tab_cnt[pos] = amount;
		tab_fill++;
	endfunction

	// apply one command to the model table and return the reply it gives
	function automatic reply_t apply_command(logic [skct_pkg::OP_W-1:0] op,
			logic [skct_pkg::KEY_W-1:0] key, logic signed [skct_pkg::CNT_W-1:0] amount);
		reply_t r;
		int     pos;
		bit     hit;
		r.status = skct_pkg::ST_NOT_FOUND;
		r.count = '0;
		pos = 0;
		while (pos < tab_fill && tab_key[pos] < key)
			pos++;
		hit = (pos < tab_fill) && (tab_key[pos] == key);
		case (op)
			skct_pkg::OP_INSERT: begin
				// full is checked ahead of the duplicate check
				if (tab_fill >= CAPACITY) begin
					r.status = skct_pkg::ST_FULL;
				end else if (hit) begin
					r.status = skct_pkg::ST_EXISTS;
				end else begin
					insert_entry(pos, key, amount);
					r.status = skct_pkg::ST_OK;
					r.count = amount;
				end
			end
			skct_pkg::OP_SEARCH: begin
				if (hit) begin
					r.status = skct_pkg::ST_OK;
					r.count = tab_cnt[pos];
				end
			end
			skct_pkg::OP_UPDATE, skct_pkg::OP_MERGE: begin
				if (hit) begin
					tab_cnt[pos] = sat_sum(tab_cnt[pos], amount);
					r.status = skct_pkg::ST_OK;
					r.count = tab_cnt[pos];
				end else if (op == skct_pkg::OP_MERGE) begin
					if (tab_fill >= CAPACITY) begin
						r.status = skct_pkg::ST_FULL;
					end else begin
						insert_entry(pos, key, amount);
						r.status = skct_pkg::ST_OK;
						r.count = amount;
					end
				end
			end
			skct_pkg::OP_ERASE: begin
				if (hit) begin
					r.count = tab_cnt[pos];
					for (int i = pos; i < tab_fill - 1; i++) begin
						tab_key[i] = tab_key[i+1];
						tab_cnt[i] = tab_cnt[i+1];
					end
					tab_fill--;
					r.status = skct_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		r.entries = skct_pkg::ENT_W'(tab_fill);
		return r;
	endfunction

	// random idle with a quiet window where both sides run flat out
	function automatic bit idle_roll();
		if (cyc >= 20000 && cyc < 35000)
			return 1'b0;
		return $urandom_range(0, 99) < 25;
	endfunction

	function automatic logic signed [skct_pkg::CNT_W-1:0] rand_amount();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $signed($urandom_range(0, 200)) - 100;
			5, 6, 7: return $urandom;
			8: return CNT_MAX - $urandom_range(0, 50);
			default: return CNT_MIN + $urandom_range(0, 50);
		endcase
	endfunction

	task automatic push_cmd(logic [skct_pkg::OP_W-1:0] op, logic [skct_pkg::KEY_W-1:0] key,
			logic signed [skct_pkg::CNT_W-1:0] amount);
		command_t c;
		c.op = op;
		c.key = key;
		c.amount = amount;
		cmd_queue.push_back(c);
	endtask

	task automatic check_field(string what, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// sender: a new command goes out once the previous transfer completed
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_xfer)) begin
			if (cmd_queue.size() != 0 && !idle_roll()) begin
				s_tvalid <= 1'b1;
				s_tuser <= cmd_queue[0].op;
				s_tdata <= {cmd_queue[0].amount, cmd_queue[0].key};
				cmd_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus long hold-offs that back the block up into its input
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if ((got_replies == 200 || got_replies == 900) && hold_mark != got_replies) begin
			hold_mark <= got_replies;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_roll();
		end
	end

	// predict on each command transfer, compare on each reply transfer
	always @(posedge clk) begin : reply_check
		reply_t want;
		cyc <= cyc + 1;
		in_xfer <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			due_replies.push_back(apply_command(s_tuser, s_tdata[23:0], $signed(s_tdata[55:24])));
		if (arst_n && m_tvalid && m_tready) begin
			got_replies <= got_replies + 1;
			if (due_replies.size() == 0) begin
				errors++;
				$display("%0t: reply with none expected, expected nothing, got status %0d count %0d",
					$time, m_tuser, $signed(m_tdata[31:0]));
			end else begin
				want = due_replies.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("count_out", want.count, $signed(m_tdata[31:0]));
				check_field("entries", want.entries, m_tdata[36:32]);
				check_field("pad bits", 0, m_tdata[39:37]);
			end
		end
	end

	initial begin
		logic [skct_pkg::KEY_W-1:0] pool[KEY_POOL];
		int                         ins_lim, mrg_lim, src_lim, upd_lim, roll;
		logic [skct_pkg::OP_W-1:0]  op;
		logic [skct_pkg::KEY_W-1:0] key;

		// directed: empty table, key and count extremes, saturation both ways, dead opcodes
		push_cmd(skct_pkg::OP_SEARCH, 24'd5, 32'sd0);
		push_cmd(skct_pkg::OP_ERASE, 24'd5, 32'sd0);
		push_cmd(skct_pkg::OP_UPDATE, 24'd5, 32'sd9);
		push_cmd(skct_pkg::OP_INSERT, '0, CNT_MIN);
		push_cmd(skct_pkg::OP_INSERT, KEY_TOP, CNT_MAX);
		push_cmd(skct_pkg::OP_INSERT, '0, 32'sd7);
		push_cmd(skct_pkg::OP_UPDATE, KEY_TOP, 32'sd1);
		push_cmd(skct_pkg::OP_UPDATE, '0, -32'sd1);
		push_cmd(skct_pkg::OP_MERGE, KEY_TOP, CNT_MAX);
		push_cmd(skct_pkg::OP_MERGE, '0, CNT_MIN);
		push_cmd(skct_pkg::OP_MERGE, KEY_MID, -32'sd5);
		push_cmd(skct_pkg::OP_SEARCH, KEY_MID, 32'sd0);
		push_cmd(skct_pkg::OP_ERASE, KEY_MID, 32'sd0);
		push_cmd(skct_pkg::OP_UPDATE, '0, CNT_MAX);
		for (int o = OP_UNUSED_FIRST; o <= OP_UNUSED_LAST; o++)
			push_cmd(o[skct_pkg::OP_W-1:0], KEY_TOP, -32'sd1);
		push_cmd(skct_pkg::OP_ERASE, '0, 32'sd0);
		push_cmd(skct_pkg::OP_ERASE, KEY_TOP, 32'sd0);

		// random: grow, mixed and shrink phases over a small key pool
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i % 400 == 0)
				foreach (pool[j])
					pool[j] = skct_pkg::KEY_W'($urandom);
			case ((i / 60) % 3)
				0: begin
					ins_lim = 40; mrg_lim = 75; src_lim = 85; upd_lim = 93;
				end
				1: begin
					ins_lim = 18; mrg_lim = 36; src_lim = 56; upd_lim = 74;
				end
				default: begin
					ins_lim = 8; mrg_lim = 16; src_lim = 30; upd_lim = 40;
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < ins_lim)
				op = skct_pkg::OP_INSERT;
			else if (roll < mrg_lim)
				op = skct_pkg::OP_MERGE;
			else if (roll < src_lim)
				op = skct_pkg::OP_SEARCH;
			else if (roll < upd_lim)
				op = skct_pkg::OP_UPDATE;
			else if (roll < 97)
				op = skct_pkg::OP_ERASE;
			else
				op = skct_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
			key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, KEY_POOL - 1)]
				: skct_pkg::KEY_W'($urandom);
			push_cmd(op, key, rand_amount());
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && due_replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#6_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
